### sv/json_string_escaper_defines.svh
// ----------------------------------------------------------------------------
// json_string_escaper_defines
// Assertion macros shared by the escaper modules
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_ESCAPER_DEFINES_SVH
`define JSON_STRING_ESCAPER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// expression holds at every clock edge out of reset
`define JSE_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("jse assertion failed");

// consequent holds in the cycle after the antecedent
`define JSE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jse assertion failed");

`else

`define JSE_ASSERT_ALWAYS(lbl, expr)
`define JSE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### sv/jse_pkg.sv
// ----------------------------------------------------------------------------
// jse_pkg
// Types, character codes and helpers for the JSON string escaper
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jse_pkg;

  localparam int BYTE_W  = 8;
  localparam int RUN_MAX = 6;
  localparam int IDX_W   = $clog2(RUN_MAX);

  // character codes
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
  localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_LOW_U  = 8'h75;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_LOW_B  = 8'h62;
  localparam logic [BYTE_W-1:0] CH_LOW_T  = 8'h74;
  localparam logic [BYTE_W-1:0] CH_LOW_N  = 8'h6E;
  localparam logic [BYTE_W-1:0] CH_LOW_F  = 8'h66;
  localparam logic [BYTE_W-1:0] CH_LOW_R  = 8'h72;
  localparam logic [BYTE_W-1:0] CH_LOW_A  = 8'h61;

  // control bytes with a short escape
  localparam logic [BYTE_W-1:0] CTL_BS = 8'h08;
  localparam logic [BYTE_W-1:0] CTL_HT = 8'h09;
  localparam logic [BYTE_W-1:0] CTL_LF = 8'h0A;
  localparam logic [BYTE_W-1:0] CTL_FF = 8'h0C;
  localparam logic [BYTE_W-1:0] CTL_CR = 8'h0D;

  // bytes below this are control bytes
  localparam logic [BYTE_W-1:0] CTRL_LIMIT = 8'd32;

  // positions inside an escape run
  localparam logic [IDX_W-1:0] POS_0 = IDX_W'(0);
  localparam logic [IDX_W-1:0] POS_1 = IDX_W'(1);
  localparam logic [IDX_W-1:0] POS_2 = IDX_W'(2);
  localparam logic [IDX_W-1:0] POS_3 = IDX_W'(3);
  localparam logic [IDX_W-1:0] POS_4 = IDX_W'(4);
  localparam logic [IDX_W-1:0] POS_LAST = IDX_W'(RUN_MAX - 1);

  // one output byte with its markers
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              run_end;
    logic              string_end;
  } beat_t;

  // lower-case hex digit for a nibble
  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
    logic [BYTE_W-1:0] wide;
    wide = {4'b0000, nib};
    if (nib < 4'd10) begin
      hex_char = wide + CH_ZERO;
    end else begin
      hex_char = wide + CH_LOW_A - 8'd10;
    end
  endfunction

endpackage

### sv/json_string_escaper.sv
// ----------------------------------------------------------------------------
// json_string_escaper
// Escapes a byte stream for use inside a JSON string literal
// ----------------------------------------------------------------------------
//   channel  dir  tdata          tuser     tlast
//   in_      in   in_byte[7:0]   -         last_byte
//   out_     out  out_byte[7:0]  run_end   string_end
//
// one output byte per cycle while out_tready is high and input keeps up; a byte passed
// through yields one byte, a short escape two and a \u00xx escape six, set by the
// run stage's position counter; input passes the run register, then the result register
// rst_n is synchronous and active low and empties both registers
// a stalled out_tready holds the result register and backs up into in_tready
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module json_string_escaper (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [jse_pkg::BYTE_W-1:0] in_tdata,   // [7:0] in_byte
  input  logic                       in_tlast,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [jse_pkg::BYTE_W-1:0] out_tdata,  // [7:0] out_byte
  output logic                       out_tuser,  // [0] run_end
  output logic                       out_tlast
);
  import jse_pkg::*;

  logic  space;
  logic  beat_valid;
  beat_t beat;
  beat_t out_beat;

  // current byte and its position in the escape run
  jse_run_stage u_run (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_byte    (in_tdata),
    .in_last    (in_tlast),
    .in_ready   (in_tready),
    .space      (space),
    .beat_valid (beat_valid),
    .beat       (beat)
  );

  // result register
  jse_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .beat_valid (beat_valid),
    .beat       (beat),
    .space      (space),
    .out_valid  (out_tvalid),
    .out_beat   (out_beat),
    .out_ready  (out_tready)
  );

  assign out_tdata = out_beat.data;
  assign out_tuser = out_beat.run_end;
  assign out_tlast = out_beat.string_end;

endmodule

### sv/jse_escape.sv
// ----------------------------------------------------------------------------
// jse_escape
// Picks the output byte at a given position of a byte's escape run
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jse_escape (
  input  logic [jse_pkg::BYTE_W-1:0] byte_i,
  input  logic [jse_pkg::IDX_W-1:0]  idx_i,
  output logic [jse_pkg::BYTE_W-1:0] data_o,
  output logic                       run_end_o
);
  import jse_pkg::*;

  logic [BYTE_W-1:0] letter;
  logic              is_short;
  logic              is_ctrl;

  // letter of a two-byte escape, zero if none
  always_comb begin
    case (byte_i)
      CTL_BS:    letter = CH_LOW_B;
      CTL_HT:    letter = CH_LOW_T;
      CTL_LF:    letter = CH_LOW_N;
      CTL_FF:    letter = CH_LOW_F;
      CTL_CR:    letter = CH_LOW_R;
      CH_QUOTE:  letter = CH_QUOTE;
      CH_SLASH:  letter = CH_SLASH;
      CH_BSLASH: letter = CH_BSLASH;
      default:   letter = '0;
    endcase
  end

  assign is_short = (letter != '0);
  assign is_ctrl  = !is_short && (byte_i < CTRL_LIMIT);

  // byte at the current position
  always_comb begin
    data_o    = byte_i;
    run_end_o = 1'b1;
    if (is_short) begin
      data_o    = (idx_i == POS_0) ? CH_BSLASH : letter;
      run_end_o = (idx_i == POS_1);
    end else if (is_ctrl) begin
      run_end_o = (idx_i == POS_LAST);
      case (idx_i)
        POS_0:   data_o = CH_BSLASH;
        POS_1:   data_o = CH_LOW_U;
        POS_2:   data_o = CH_ZERO;
        POS_3:   data_o = CH_ZERO;
        POS_4:   data_o = hex_char(byte_i[7:4]);
        default: data_o = hex_char(byte_i[3:0]);
      endcase
    end
  end

endmodule

### sv/jse_run_stage.sv
// ----------------------------------------------------------------------------
// jse_run_stage
// Holds the current input byte and steps through its escape run
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "json_string_escaper_defines.svh"

module jse_run_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [jse_pkg::BYTE_W-1:0] in_byte,
  input  logic                       in_last,
  output logic                       in_ready,
  input  logic                       space,
  output logic                       beat_valid,
  output jse_pkg::beat_t             beat
);
  import jse_pkg::*;

  logic              vld_r, vld_nxt;
  logic [BYTE_W-1:0] byte_r, byte_nxt;
  logic              last_r, last_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [BYTE_W-1:0] esc_data;
  logic              esc_end;
  logic              take;
  logic              accept;

  jse_escape u_escape (
    .byte_i    (byte_r),
    .idx_i     (idx_r),
    .data_o    (esc_data),
    .run_end_o (esc_end)
  );

  assign beat_valid      = vld_r;
  assign beat.data       = esc_data;
  assign beat.run_end    = esc_end;
  assign beat.string_end = esc_end & last_r;

  // a beat moves on when the output register has room
  assign take     = vld_r & space;
  assign in_ready = !vld_r || (take && esc_end);
  assign accept   = in_valid & in_ready;

  // next run state
  always_comb begin
    vld_nxt  = vld_r;
    byte_nxt = byte_r;
    last_nxt = last_r;
    idx_nxt  = idx_r;
    if (take) begin
      if (esc_end) begin
        vld_nxt = 1'b0;
        idx_nxt = '0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
    if (accept) begin
      vld_nxt  = 1'b1;
      byte_nxt = in_byte;
      last_nxt = in_last;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    last_r <= last_nxt;
  end

  `JSE_ASSERT_ALWAYS(a_idx_range, !vld_r || (idx_r <= POS_LAST))
  `JSE_ASSERT_NEXT(a_step, take && !esc_end, vld_r && (idx_r == $past(idx_r) + 1'b1))
  `JSE_ASSERT_NEXT(a_hold, vld_r && !take, vld_r && $stable(byte_r) && $stable(idx_r))
  `JSE_ASSERT_NEXT(a_load, accept, vld_r && (idx_r == POS_0))

endmodule

### sv/jse_out_reg.sv
// ----------------------------------------------------------------------------
// jse_out_reg
// Result register between the run stage and the output channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "json_string_escaper_defines.svh"

module jse_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           beat_valid,
  input  jse_pkg::beat_t beat,
  output logic           space,
  output logic           out_valid,
  output jse_pkg::beat_t out_beat,
  input  logic           out_ready
);
  import jse_pkg::*;

  logic  vld_r, vld_nxt;
  beat_t beat_r, beat_nxt;
  logic  load;

  // room when empty or being emptied this cycle
  assign space     = !vld_r || out_ready;
  assign load      = beat_valid & space;
  assign out_valid = vld_r;
  assign out_beat  = beat_r;

  always_comb begin
    vld_nxt  = vld_r;
    beat_nxt = beat_r;
    if (load) begin
      vld_nxt  = 1'b1;
      beat_nxt = beat;
    end else if (out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    beat_r <= beat_nxt;
  end

  `JSE_ASSERT_ALWAYS(a_string_end_in_run, !vld_r || !beat_r.string_end || beat_r.run_end)
  `JSE_ASSERT_NEXT(a_load_shows, load, vld_r && (beat_r == $past(beat)))

endmodule

### verif/tb_json_string_escaper.sv
// ----------------------------------------------------------------------------
// tb_json_string_escaper
// Self-checking bench for the JSON string escaper: a directed table of bytes
// and then random strings are streamed in; each output transfer is checked
// against the expected escape runs, under varying backpressure on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_json_string_escaper;

  import jse_pkg::*;

  localparam int RANDOM_ITEMS = 360;
  localparam int MAX_REPORTS  = 10;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 8;

  // directed row: an input byte and, when fix_len is nonzero, its known run
  // (first output byte in the highest used bits)
  typedef struct {
    logic [BYTE_W-1:0] data_in;
    logic              is_last;
    int                fix_len;
    logic [47:0]       fix_run;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [BYTE_W-1:0] in_tdata;   // [7:0] in_byte
  logic in_tlast;
  logic out_tvalid;
  logic out_tready;
  logic [BYTE_W-1:0] out_tdata;  // [7:0] out_byte
  logic out_tuser;               // [0] run_end
  logic out_tlast;

  beat_t escaped_q[$];
  int    bytes_taken = 0;
  int    mismatches  = 0;
  int    cur_fix_len = 0;
  logic [47:0] cur_fix_run = '0;
  string hex_digits = "0123456789abcdef";

  json_string_escaper dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // idle rates move through three phases as input transfers go by
  function automatic int sender_idle_pct(input int n);
    sender_idle_pct = (n < 150) ? 7 : (n < 290) ? 88 : 0;
  endfunction

  function automatic int receiver_idle_pct(input int n);
    receiver_idle_pct = (n < 150) ? 88 : (n < 290) ? 7 : 0;
  endfunction

  // expected escape run for one input byte
  function automatic void predict_escape(input logic [BYTE_W-1:0] b, input logic is_last);
    logic [BYTE_W-1:0] run [RUN_MAX];
    logic [BYTE_W-1:0] letter;
    int n;
    letter = 8'h00;
    case (b)
      CTL_BS:    letter = CH_LOW_B;
      CTL_HT:    letter = CH_LOW_T;
      CTL_LF:    letter = CH_LOW_N;
      CTL_FF:    letter = CH_LOW_F;
      CTL_CR:    letter = CH_LOW_R;
      CH_QUOTE:  letter = CH_QUOTE;
      CH_SLASH:  letter = CH_SLASH;
      CH_BSLASH: letter = CH_BSLASH;
      default:   letter = 8'h00;
    endcase
    if (letter != 8'h00) begin
      run[0] = CH_BSLASH;
      run[1] = letter;
      n = 2;
    end else if (b < CTRL_LIMIT) begin
      run[0] = CH_BSLASH;
      run[1] = CH_LOW_U;
      run[2] = CH_ZERO;
      run[3] = CH_ZERO;
      run[4] = hex_digits[b[7:4]];
      run[5] = hex_digits[b[3:0]];
      n = 6;
    end else begin
      run[0] = b;
      n = 1;
    end
    for (int k = 0; k < n; k++) begin
      escaped_q.push_back('{data: run[k], run_end: (k == n - 1),
                            string_end: (k == n - 1) && is_last});
    end
  endfunction

  // random byte, weighted toward the escaped classes
  function automatic logic [BYTE_W-1:0] pick_byte();
    logic [BYTE_W-1:0] short_esc [8];
    int sel;
    short_esc = '{CTL_BS, CTL_HT, CTL_LF, CTL_FF, CTL_CR, CH_QUOTE, CH_SLASH, CH_BSLASH};
    sel = $urandom_range(99);
    if (sel < 35) pick_byte = BYTE_W'($urandom_range(8'h7E, 8'h20));
    else if (sel < 55) pick_byte = short_esc[$urandom_range(7)];
    else if (sel < 75) pick_byte = BYTE_W'($urandom_range(31));
    else if (sel < 90) pick_byte = BYTE_W'($urandom_range(255, 128));
    else pick_byte = BYTE_W'($urandom_range(255));
  endfunction

  // offer one byte, with random gaps ahead of it; returns at a falling edge
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic is_last,
                           input int fix_len, input logic [47:0] fix_run);
    while ($urandom_range(99) < sender_idle_pct(bytes_taken)) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid   <= 1'b1;
    in_tdata    <= b;
    in_tlast    <= is_last;
    cur_fix_len = fix_len;
    cur_fix_run = fix_run;
    do @(posedge clk); while (in_tready !== 1'b1);
    @(negedge clk);
  endtask

  // record expectations on input transfers, check output transfers
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (in_tvalid && in_tready === 1'b1) begin
        bytes_taken++;
        if (cur_fix_len > 0) begin
          for (int k = 0; k < cur_fix_len; k++) begin
            escaped_q.push_back('{data: cur_fix_run[8*(cur_fix_len-1-k) +: 8],
                                  run_end: (k == cur_fix_len - 1),
                                  string_end: (k == cur_fix_len - 1) && in_tlast});
          end
        end else begin
          predict_escape(in_tdata, in_tlast);
        end
      end
      if (out_tvalid === 1'b1 && out_tready) begin
        if (escaped_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected output byte %h run_end %b string_end %b",
                     $realtime, out_tdata, out_tuser, out_tlast);
        end else begin
          beat_t want;
          want = escaped_q.pop_front();
          if (out_tdata !== want.data || out_tuser !== want.run_end ||
              out_tlast !== want.string_end) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: output mismatch, expected %h/%b/%b got %h/%b/%b",
                       $realtime, want.data, want.run_end, want.string_end,
                       out_tdata, out_tuser, out_tlast);
          end
        end
      end
    end
  end

  // receiver: random stalls, plus one long hold-off to back up the input
  initial begin
    int hold_left;
    bit long_hold_done;
    hold_left = 0;
    long_hold_done = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst_n !== 1'b1) begin
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (!long_hold_done && bytes_taken >= 40) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= receiver_idle_pct(bytes_taken));
      end
    end
  end

  // stimulus and end of run
  initial begin
    dir_row_t dir_rows [];
    int len;
    int sent;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tlast  = 1'b0;

    dir_rows = '{
      '{8'h00, 1'b1, 6, "\\u0000"},  // zero byte alone as a string
      '{8'hFF, 1'b1, 1, 48'hFF},     // top byte passes through
      '{8'h1F, 1'b0, 6, "\\u001f"},
      '{8'h20, 1'b0, 1, " "},
      '{8'h7F, 1'b0, 1, 48'h7F},
      '{8'h80, 1'b1, 1, 48'h80},
      '{CTL_BS, 1'b0, 0, '0},
      '{CTL_HT, 1'b0, 0, '0},
      '{CTL_LF, 1'b0, 0, '0},
      '{CTL_FF, 1'b0, 0, '0},
      '{CTL_CR, 1'b1, 0, '0},
      '{CH_QUOTE, 1'b0, 0, '0},
      '{CH_SLASH, 1'b0, 0, '0},
      '{CH_BSLASH, 1'b1, 0, '0},
      '{8'h0B, 1'b0, 0, '0},
      '{8'h01, 1'b0, 0, '0},
      '{8'h10, 1'b1, 0, '0},
      '{8'h1E, 1'b0, 0, '0},
      '{8'h41, 1'b0, 0, '0},
      '{8'h55, 1'b0, 0, '0},
      '{8'hAA, 1'b1, 0, '0}
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      send_byte(dir_rows[i].data_in, dir_rows[i].is_last,
                dir_rows[i].fix_len, dir_rows[i].fix_run);
    end

    // random strings of one to twelve bytes
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len = $urandom_range(12, 1);
      for (int k = 0; k < len; k++) begin
        send_byte(pick_byte(), k == len - 1, 0, '0);
      end
      sent += len;
    end
    in_tvalid <= 1'b0;

    while (escaped_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && escaped_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
